// ===== hdl/rde_pkg.sv =====
package rde_pkg;

   localparam int DEFAULT_DEPTH        = 128;
   localparam int DEFAULT_ELEMENT_BITS = 8;

   localparam int REQ_BITS    = 3;
   localparam int STATUS_BITS = 2;

   localparam logic [REQ_BITS-1:0] REQ_CLEAR   = 3'd0;
   localparam logic [REQ_BITS-1:0] REQ_APPEND  = 3'd1;
   localparam logic [REQ_BITS-1:0] REQ_REVERSE = 3'd2;
   localparam logic [REQ_BITS-1:0] REQ_DELETE  = 3'd3;
   localparam logic [REQ_BITS-1:0] REQ_READ    = 3'd4;

   localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_ERROR = 2'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd3;

   typedef enum logic [2:0] {
      OP_CLEAR,
      OP_APPEND,
      OP_REVERSE,
      OP_DELETE,
      OP_READ,
      OP_NONE
   } op_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } cmd_type;

endpackage

// ===== hdl/rde_front.sv =====
module rde_front
   import rde_pkg::*;
#(
   parameter int ELEMENT_BITS = DEFAULT_ELEMENT_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [REQ_BITS-1:0]     req_type,
   input  logic [ELEMENT_BITS-1:0] req_element_in,
   output cmd_type                 cmd,
   output logic [ELEMENT_BITS-1:0] cmd_element,
   input  logic                    cmd_pop
);

   // Two-entry queue of decoded requests between the request channel and the back end.
   op_type                  op_ff      [2];
   logic [ELEMENT_BITS-1:0] element_ff [2];
   logic                    wr_ptr_ff, wr_ptr_in;
   logic                    rd_ptr_ff, rd_ptr_in;
   logic [1:0]              fill_ff, fill_in;
   logic                    push;
   op_type                  op_dec;

   always_comb begin
      case (req_type)
         REQ_CLEAR:   op_dec = OP_CLEAR;
         REQ_APPEND:  op_dec = OP_APPEND;
         REQ_REVERSE: op_dec = OP_REVERSE;
         REQ_DELETE:  op_dec = OP_DELETE;
         REQ_READ:    op_dec = OP_READ;
         default:     op_dec = OP_NONE;
      endcase
   end

   assign req_stall = (fill_ff == 2'd2);
   assign push      = req_valid && !req_stall;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, cmd_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         op_ff[wr_ptr_ff]      <= op_dec;
         element_ff[wr_ptr_ff] <= req_element_in;
      end
   end

   assign cmd.valid   = (fill_ff != 2'd0);
   assign cmd.op      = op_ff[rd_ptr_ff];
   assign cmd_element = element_ff[rd_ptr_ff];

endmodule

// ===== hdl/rde_back.sv =====
module rde_back
   import rde_pkg::*;
#(
   parameter int DEPTH        = DEFAULT_DEPTH,
   parameter int ELEMENT_BITS = DEFAULT_ELEMENT_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  cmd_type                 cmd,
   input  logic [ELEMENT_BITS-1:0] cmd_element,
   output logic                    cmd_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [ELEMENT_BITS-1:0] rsp_element_out,
   output logic [STATUS_BITS-1:0]  rsp_status,
   output logic                    rsp_last_element
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;

   logic [ELEMENT_BITS-1:0] store_ff [DEPTH];
   logic [ELEMENT_BITS-1:0] rd_data_ff;

   logic [IW-1:0]          head_ff, head_in;
   logic [CW-1:0]          count_ff, count_in;
   logic                   reversed_ff, reversed_in;
   logic                   error_ff, error_in;

   logic                   rsp_valid_ff;
   logic [STATUS_BITS-1:0] status_ff, status_in;
   logic                   last_ff, last_in;
   logic                   is_read_ff, is_read_in;

   logic                   issue;
   logic                   wr_en;
   logic                   rd_en;
   logic [IW-1:0]          addr;
   logic [IW-1:0]          front_addr;
   logic [IW-1:0]          tail_addr;
   logic [IW-1:0]          next_head;
   logic                   is_empty;
   logic                   is_full;

   function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] base,
                                             input logic [CW-1:0] off);
      logic [SW-1:0] sum;
      sum = SW'(base) + SW'(off);
      if (sum >= SW'(DEPTH)) begin
         sum = sum - SW'(DEPTH);
      end
      return sum[IW-1:0];
   endfunction

   assign issue   = cmd.valid && (!rsp_valid_ff || !rsp_stall);
   assign cmd_pop = issue;

   assign is_empty   = (count_ff == '0);
   assign is_full    = (count_ff == CW'(DEPTH));
   assign front_addr = reversed_ff ? slot_of(head_ff, count_ff - CW'(1)) : head_ff;
   assign tail_addr  = slot_of(head_ff, count_ff);
   assign next_head  = slot_of(head_ff, CW'(1));

   always_comb begin
      head_in     = head_ff;
      count_in    = count_ff;
      reversed_in = reversed_ff;
      error_in    = error_ff;
      status_in   = STATUS_OK;
      last_in     = 1'b0;
      is_read_in  = 1'b0;
      wr_en       = 1'b0;
      rd_en       = 1'b0;
      addr        = front_addr;
      if (issue) begin
         case (cmd.op)
            OP_CLEAR: begin
               head_in     = '0;
               count_in    = '0;
               reversed_in = 1'b0;
               error_in    = 1'b0;
            end
            OP_APPEND: begin
               if (error_ff) begin
                  status_in = STATUS_ERROR;
               end else if (is_full) begin
                  status_in = STATUS_FULL;
               end else begin
                  wr_en    = 1'b1;
                  addr     = tail_addr;
                  count_in = count_ff + CW'(1);
               end
            end
            OP_REVERSE: begin
               reversed_in = !reversed_ff;
            end
            OP_DELETE: begin
               if (error_ff) begin
                  status_in = STATUS_ERROR;
               end else if (is_empty) begin
                  error_in  = 1'b1;
                  status_in = STATUS_ERROR;
               end else begin
                  count_in = count_ff - CW'(1);
                  if (!reversed_ff) begin
                     head_in = next_head;
                  end
               end
            end
            OP_READ: begin
               if (error_ff) begin
                  status_in = STATUS_ERROR;
               end else if (is_empty) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  rd_en      = 1'b1;
                  is_read_in = 1'b1;
                  last_in    = (count_ff == CW'(1));
                  count_in   = count_ff - CW'(1);
                  if (!reversed_ff) begin
                     head_in = next_head;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         reversed_ff  <= 1'b0;
         error_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff     <= head_in;
         count_ff    <= count_in;
         reversed_ff <= reversed_in;
         error_ff    <= error_in;
         if (issue) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         status_ff  <= status_in;
         last_ff    <= last_in;
         is_read_ff <= is_read_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[addr] <= cmd_element;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[addr];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_element_out  = is_read_ff ? rd_data_ff : '0;
   assign rsp_status       = status_ff;
   assign rsp_last_element = last_ff;

endmodule

// ===== hdl/reversible_deque_engine.sv =====
// Deque held in a ring buffer, with a direction flag that sets which end is read.
// Request channel: req_type selects clear, append, reverse, delete or read; the
// append value comes on req_element_in. A transfer happens when req_valid is high
// and req_stall is low. Every request gives exactly one transfer on the response
// channel, in request order, with rsp_element_out, rsp_status and rsp_last_element.
// A request is registered in the two-entry queue, and the execute stage then registers
// the response and the storage read at the same edge; the response is offered from
// that register. The block takes one request per cycle for as long as the receiver
// keeps rsp_stall low; each request touches at most one storage entry.
// When the receiver stalls, the response register holds its value, the execute
// stage waits, and req_stall rises once both queue entries are occupied.
// Reset clears the list, the direction flag and the sticky delete error, and
// empties the queue and the response register; storage contents are not cleared
// and need no clearing pass, since only entries that were written are read.
module reversible_deque_engine
   import rde_pkg::*;
#(
   parameter int DEPTH        = DEFAULT_DEPTH,
   parameter int ELEMENT_BITS = DEFAULT_ELEMENT_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [REQ_BITS-1:0]     req_type,
   input  logic [ELEMENT_BITS-1:0] req_element_in,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [ELEMENT_BITS-1:0] rsp_element_out,
   output logic [STATUS_BITS-1:0]  rsp_status,
   output logic                    rsp_last_element
);

   cmd_type                 cmd;
   logic [ELEMENT_BITS-1:0] cmd_element;
   logic                    cmd_pop;

   rde_front #(
      .ELEMENT_BITS (ELEMENT_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_element_in (req_element_in),
      .cmd            (cmd),
      .cmd_element    (cmd_element),
      .cmd_pop        (cmd_pop)
   );

   rde_back #(
      .DEPTH        (DEPTH),
      .ELEMENT_BITS (ELEMENT_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .cmd_element      (cmd_element),
      .cmd_pop          (cmd_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_element_out  (rsp_element_out),
      .rsp_status       (rsp_status),
      .rsp_last_element (rsp_last_element)
   );

endmodule

// ===== bench/rde_response_checker.sv =====
`timescale 1ns / 100ps

module rde_response_checker
   import rde_pkg::*;
#(
   parameter int DEPTH        = DEFAULT_DEPTH,
   parameter int ELEMENT_BITS = DEFAULT_ELEMENT_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_stall,
   input  logic [REQ_BITS-1:0]     req_type,
   input  logic [ELEMENT_BITS-1:0] req_element_in,
   input  logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  logic [ELEMENT_BITS-1:0] rsp_element_out,
   input  logic [STATUS_BITS-1:0]  rsp_status,
   input  logic                    rsp_last_element,
   output int                      mismatches,
   output int                      outstanding,
   output int                      compared,
   output int                      peak_fill,
   output int                      full_drops
);

   localparam int AWAIT_DEPTH = 16;

   typedef struct packed {
      logic [ELEMENT_BITS-1:0] element;
      logic [STATUS_BITS-1:0]  status;
      logic                    last;
   } deque_result_type;

   logic [ELEMENT_BITS-1:0] slots [DEPTH];
   int                      head_slot;
   int                      fill;
   bit                      flipped;
   bit                      faulted;
   deque_result_type        awaited_results [AWAIT_DEPTH];
   int                      await_wr_count;
   int                      await_rd_count;

   // Takes the front element in the current reading direction.
   function automatic logic [ELEMENT_BITS-1:0] take_front();
      int slot;
      if (flipped) begin
         slot = (head_slot + fill - 1) % DEPTH;
      end else begin
         slot = head_slot;
         head_slot = (head_slot + 1) % DEPTH;
      end
      fill--;
      return slots[slot];
   endfunction

   function automatic deque_result_type apply_request(input logic [REQ_BITS-1:0] kind,
                                                      input logic [ELEMENT_BITS-1:0] value);
      deque_result_type outcome;
      outcome = '0;
      outcome.status = STATUS_OK;
      case (kind)
         REQ_CLEAR: begin
            head_slot = 0;
            fill = 0;
            flipped = 1'b0;
            faulted = 1'b0;
         end
         REQ_APPEND: begin
            if (faulted) begin
               outcome.status = STATUS_ERROR;
            end else if (fill >= DEPTH) begin
               outcome.status = STATUS_FULL;
               full_drops++;
            end else begin
               slots[(head_slot + fill) % DEPTH] = value;
               fill++;
               if (fill > peak_fill) peak_fill = fill;
            end
         end
         REQ_REVERSE: begin
            flipped = !flipped;
         end
         REQ_DELETE: begin
            if (faulted) begin
               outcome.status = STATUS_ERROR;
            end else if (fill == 0) begin
               faulted = 1'b1;
               outcome.status = STATUS_ERROR;
            end else begin
               void'(take_front());
            end
         end
         REQ_READ: begin
            if (faulted) begin
               outcome.status = STATUS_ERROR;
            end else if (fill == 0) begin
               outcome.status = STATUS_EMPTY;
            end else begin
               outcome.element = take_front();
               outcome.last = (fill == 0);
            end
         end
         default: begin
         end
      endcase
      return outcome;
   endfunction

   task automatic report_mismatch(input string detail);
      mismatches++;
      $display("%0t ns: response %0d: %s", $time, compared, detail);
   endtask

   always @(posedge clock) begin
      deque_result_type want;
      if (reset) begin
         head_slot = 0;
         fill = 0;
         flipped = 1'b0;
         faulted = 1'b0;
         await_wr_count = 0;
         await_rd_count = 0;
      end else begin
         if (req_valid && !req_stall) begin
            if (await_wr_count - await_rd_count >= AWAIT_DEPTH) begin
               report_mismatch("more requests outstanding than the block can hold");
            end else begin
               awaited_results[await_wr_count % AWAIT_DEPTH] =
                  apply_request(req_type, req_element_in);
               await_wr_count++;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            compared++;
            if (await_wr_count == await_rd_count) begin
               report_mismatch("transfer with no request outstanding");
            end else begin
               want = awaited_results[await_rd_count % AWAIT_DEPTH];
               await_rd_count++;
               if (rsp_element_out !== want.element) begin
                  report_mismatch($sformatf("element_out %0h, expected %0h",
                                            rsp_element_out, want.element));
               end
               if (rsp_status !== want.status) begin
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_status, want.status));
               end
               if (rsp_last_element !== want.last) begin
                  report_mismatch($sformatf("last_element %0b, expected %0b",
                                            rsp_last_element, want.last));
               end
            end
         end
      end
      outstanding = await_wr_count - await_rd_count;
   end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
   import rde_pkg::*;

   localparam int IDLE_LIMIT     = 1000;
   localparam int REQUEST_TARGET = 600;
   localparam int CALM_TAIL      = 120;

   logic                            clock;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [REQ_BITS-1:0]             req_type = REQ_CLEAR;
   logic [DEFAULT_ELEMENT_BITS-1:0] req_element_in = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [DEFAULT_ELEMENT_BITS-1:0] rsp_element_out;
   logic [STATUS_BITS-1:0]          rsp_status;
   logic                            rsp_last_element;

   int mismatches;
   int outstanding;
   int compared;
   int peak_fill;
   int full_drops;
   int req_sent;
   int idle_cycles;
   int stall_run;
   bit gaps_on;

   reversible_deque_engine DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_element_in   (req_element_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_element_out  (rsp_element_out),
      .rsp_status       (rsp_status),
      .rsp_last_element (rsp_last_element)
   );

   rde_response_checker response_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_element_in   (req_element_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_element_out  (rsp_element_out),
      .rsp_status       (rsp_status),
      .rsp_last_element (rsp_last_element),
      .mismatches       (mismatches),
      .outstanding      (outstanding),
      .compared         (compared),
      .peak_fill        (peak_fill),
      .full_drops       (full_drops)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      if (stall_run > 0) begin
         stall_run <= stall_run - 1;
         rsp_stall <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
         stall_run <= $urandom_range(0, 2);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == IDLE_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles.", IDLE_LIMIT);
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic logic [DEFAULT_ELEMENT_BITS-1:0] random_element();
      return DEFAULT_ELEMENT_BITS'($urandom_range(0, 255));
   endfunction

   task automatic push_request(input logic [REQ_BITS-1:0] kind,
                               input logic [DEFAULT_ELEMENT_BITS-1:0] value);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_element_in <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      req_sent++;
   endtask

   // Clears the list, appends past capacity so that drops occur, then reads a few back.
   task automatic fill_run();
      push_request(REQ_CLEAR, random_element());
      for (int i = 0; i < DEFAULT_DEPTH + $urandom_range(1, 3); i++) begin
         if ($urandom_range(0, 24) == 0) push_request(REQ_REVERSE, random_element());
         push_request(REQ_APPEND, random_element());
      end
      repeat ($urandom_range(4, 12)) push_request(REQ_READ, random_element());
   endtask

   task automatic mixed_run(input int count);
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            push_request(REQ_APPEND, random_element());
         end else if (pick < 64) begin
            push_request(REQ_READ, random_element());
         end else if (pick < 76) begin
            push_request(REQ_DELETE, random_element());
         end else if (pick < 88) begin
            push_request(REQ_REVERSE, random_element());
         end else if (pick < 94) begin
            push_request(REQ_READ + REQ_BITS'($urandom_range(1, 3)), random_element());
         end else begin
            push_request(REQ_CLEAR, random_element());
         end
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      gaps_on = 1'b1;

      push_request(REQ_READ, 8'h00);
      push_request(REQ_APPEND, 8'h00);
      push_request(REQ_APPEND, 8'hFF);
      push_request(REQ_APPEND, 8'h5A);
      push_request(REQ_READ, 8'h00);
      push_request(REQ_REVERSE, 8'h00);
      push_request(REQ_READ, 8'h00);
      push_request(REQ_APPEND, 8'hA5);
      push_request(REQ_READ, 8'h00);
      push_request(REQ_READ, 8'h00);
      push_request(REQ_READ, 8'h00);
      push_request(REQ_DELETE, 8'h00);
      push_request(REQ_APPEND, 8'h3C);
      push_request(REQ_READ, 8'h00);
      push_request(REQ_DELETE, 8'h00);
      push_request(REQ_REVERSE, 8'h00);
      push_request(REQ_CLEAR, 8'h00);
      push_request(REQ_READ + 3'd1, 8'hFF);
      push_request(REQ_READ + 3'd2, 8'hFF);
      push_request(REQ_READ + 3'd3, 8'hFF);
      push_request(REQ_APPEND, 8'h81);
      push_request(REQ_APPEND, 8'h7E);
      push_request(REQ_REVERSE, 8'h00);
      push_request(REQ_DELETE, 8'h00);
      push_request(REQ_READ, 8'h00);

      fill_run();
      while (req_sent < REQUEST_TARGET) begin
         gaps_on = (req_sent < REQUEST_TARGET - CALM_TAIL) && ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 19) == 0 && req_sent < 350) begin
            fill_run();
         end else begin
            mixed_run($urandom_range(8, 30));
            if ($urandom_range(0, 1) == 1) push_request(REQ_CLEAR, random_element());
         end
      end
      req_valid <= 1'b0;
      gaps_on = 1'b0;

      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d requests and compared %0d responses.", req_sent, compared);
      $display("The list peaked at %0d of %0d entries with %0d appends dropped as full.",
               peak_fill, DEFAULT_DEPTH, full_drops);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
